// File: hw/rtl/stq_pkg.sv
// shared constants and codes for the sorted task queue
package stq_pkg;

  localparam int unsigned DefCapacity = 16;

  localparam int unsigned TaskW = 8;
  localparam int unsigned KeyW  = 32;
  localparam int unsigned KindW = 2;

  // beat widths, rounded up to whole bytes
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 56;

  // operation codes carried on tuser
  localparam logic [KindW-1:0] KindAppend = 2'd0;
  localparam logic [KindW-1:0] KindInsert = 2'd1;
  localparam logic [KindW-1:0] KindPop    = 2'd2;

endpackage

// File: hw/rtl/sorted_task_queue.sv
// bounded task queue kept as a linked list in on-chip slot memories
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+-------------------------------------------------
//  s_axis   | in  | tvalid / tready | tuser: kind; tdata: task_id, key
//  m_axis   | out | tvalid / tready | tdata: popped_valid, popped_task, popped_key,
//           |     |                 |        queue_empty, head_task, insert_dropped
//
//  one beat in is handled at a time; every input beat gives exactly one output beat
//  a sorted insert into an empty queue or as the new head needs no walk, otherwise it
//  reads the list node by node from the head; the walk is bound by the single read
//  port of the slot memories, one node per cycle
//  reset empties the queue and chains every slot into the free list at once
//  (per-slot valid bits stand in for the initial link values), no clearing pass
//  a stalled output beat only holds back the last cycle of the next beat

module sorted_task_queue
  import stq_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave side
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [7:0] task_id, [39:8] key
  input  logic [KindW-1:0]    s_axis_tuser,   // [1:0] kind
  // master side
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // [0] popped_valid, [8:1] popped_task,
                                              // [40:9] popped_key, [41] queue_empty,
                                              // [49:42] head_task, [50] insert_dropped
);

  // slot index width and pointer width (pointer also codes the null slot)
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned PW = $clog2(CAPACITY + 1);
  localparam logic [PW-1:0] NullSlot = PW'(CAPACITY);

  // sequencer states
  localparam logic [3:0] StIdle   = 4'd0;  // waiting for a beat
  localparam logic [3:0] StAlloc  = 4'd1;  // free slot's link arrives, store entry
  localparam logic [3:0] StLTail  = 4'd2;  // hang the new slot on the tail
  localparam logic [3:0] StCmpH   = 4'd3;  // compare against the head node
  localparam logic [3:0] StWalk   = 4'd4;  // one list node per cycle
  localparam logic [3:0] StSplice = 4'd5;  // point the predecessor at the new slot
  localparam logic [3:0] StPop    = 4'd6;  // head node arrives, unlink it
  localparam logic [3:0] StHdRd   = 4'd7;  // task of the new head arrives
  localparam logic [3:0] StDone   = 4'd8;  // hand the result to the output register

  logic [3:0]        state_q, state_d;

  // latched input beat
  logic [KindW-1:0]  kind_q;
  logic [TaskW-1:0]  task_q;
  logic [KeyW-1:0]   key_q;

  // list pointers
  logic [PW-1:0]     head_q, head_d;
  logic [PW-1:0]     tail_q, tail_d;
  logic [PW-1:0]     free_q, free_d;
  logic [TaskW-1:0]  head_task_q, head_task_d;

  // walk and allocation registers
  logic [IW-1:0]     slot_q, slot_d;
  logic [IW-1:0]     cur_q, cur_d;
  logic [PW-1:0]     nxt_q, nxt_d;

  // result staging
  logic              pv_q, pv_d;
  logic [TaskW-1:0]  pt_q, pt_d;
  logic [KeyW-1:0]   pk_q, pk_d;
  logic              drop_q, drop_d;

  // output register
  logic                m_tvalid_q;
  logic [OutDataW-1:0] m_tdata_q;
  logic                out_load;

  // memory ports
  logic              rd_en;
  logic [IW-1:0]     rd_addr;
  logic              dat_we;
  logic              lnk_we;
  logic [IW-1:0]     lnk_addr;
  logic [PW-1:0]     lnk_wdata;

  logic [TaskW-1:0]  mem_task [CAPACITY];
  logic [KeyW-1:0]   mem_key  [CAPACITY];
  logic [PW-1:0]     mem_link [CAPACITY];
  logic [CAPACITY-1:0] link_vld_q;

  logic [TaskW-1:0]  rd_task_q;
  logic [KeyW-1:0]   rd_key_q;
  logic [PW-1:0]     rd_link_raw_q;
  logic              rd_vld_q;
  logic [IW-1:0]     rd_idx_q;
  logic [PW-1:0]     rd_link;

  logic              in_acc;
  logic              head_null;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign head_null     = (head_q >= NullSlot);

  // a link never written still holds its place in the reset free chain
  assign rd_link = rd_vld_q ? rd_link_raw_q : (PW'(rd_idx_q) + PW'(1));

  // ---------------------------------------------------------------------------
  // slot memories, one shared read address, registered read data
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (dat_we) begin
      mem_task[slot_q] <= task_q;
      mem_key[slot_q]  <= key_q;
    end
    if (lnk_we) begin
      mem_link[lnk_addr] <= lnk_wdata;
    end
    if (rd_en) begin
      rd_task_q     <= mem_task[rd_addr];
      rd_key_q      <= mem_key[rd_addr];
      rd_link_raw_q <= mem_link[rd_addr];
      rd_idx_q      <= rd_addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (lnk_we) begin
        link_vld_q[lnk_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= link_vld_q[rd_addr];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    free_d      = free_q;
    head_task_d = head_task_q;
    slot_d      = slot_q;
    cur_d       = cur_q;
    nxt_d       = nxt_q;
    pv_d        = pv_q;
    pt_d        = pt_q;
    pk_d        = pk_q;
    drop_d      = drop_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    dat_we      = 1'b0;
    lnk_we      = 1'b0;
    lnk_addr    = slot_q;
    lnk_wdata   = NullSlot;
    out_load    = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          pv_d   = 1'b0;
          pt_d   = '0;
          pk_d   = '0;
          drop_d = 1'b0;
          if (s_axis_tuser == KindAppend || s_axis_tuser == KindInsert) begin
            if (free_q >= NullSlot) begin
              drop_d  = 1'b1;
              state_d = StDone;
            end else begin
              rd_en   = 1'b1;
              rd_addr = free_q[IW-1:0];
              slot_d  = free_q[IW-1:0];
              state_d = StAlloc;
            end
          end else if (s_axis_tuser == KindPop) begin
            if (head_null) begin
              state_d = StDone;
            end else begin
              rd_en   = 1'b1;
              rd_addr = head_q[IW-1:0];
              slot_d  = head_q[IW-1:0];
              state_d = StPop;
            end
          end else begin
            state_d = StDone;
          end
        end
      end

      StAlloc: begin
        free_d = rd_link;
        dat_we = 1'b1;
        if (kind_q == KindAppend || head_null) begin
          lnk_we    = 1'b1;
          lnk_addr  = slot_q;
          lnk_wdata = NullSlot;
          state_d   = StLTail;
        end else begin
          rd_en   = 1'b1;
          rd_addr = head_q[IW-1:0];
          state_d = StCmpH;
        end
      end

      StLTail: begin
        tail_d = PW'(slot_q);
        if (head_null) begin
          head_d      = PW'(slot_q);
          head_task_d = task_q;
        end else begin
          lnk_we    = 1'b1;
          lnk_addr  = tail_q[IW-1:0];
          lnk_wdata = PW'(slot_q);
        end
        state_d = StDone;
      end

      StCmpH, StWalk: begin
        if (state_q == StCmpH && key_q < rd_key_q) begin
          // new smallest key takes the head
          lnk_we      = 1'b1;
          lnk_addr    = slot_q;
          lnk_wdata   = head_q;
          head_d      = PW'(slot_q);
          head_task_d = task_q;
          state_d     = StDone;
        end else if (state_q == StWalk && key_q <= rd_key_q) begin
          // goes ahead of this node
          lnk_we    = 1'b1;
          lnk_addr  = slot_q;
          lnk_wdata = nxt_q;
          state_d   = StSplice;
        end else begin
          cur_d = (state_q == StCmpH) ? head_q[IW-1:0] : nxt_q[IW-1:0];
          if (rd_link >= NullSlot) begin
            // end of list reached
            lnk_we    = 1'b1;
            lnk_addr  = slot_q;
            lnk_wdata = NullSlot;
            nxt_d     = NullSlot;
            state_d   = StSplice;
          end else begin
            nxt_d   = rd_link;
            rd_en   = 1'b1;
            rd_addr = rd_link[IW-1:0];
            state_d = StWalk;
          end
        end
      end

      StSplice: begin
        lnk_we    = 1'b1;
        lnk_addr  = cur_q;
        lnk_wdata = PW'(slot_q);
        if (nxt_q >= NullSlot) begin
          tail_d = PW'(slot_q);
        end
        state_d = StDone;
      end

      StPop: begin
        pv_d      = 1'b1;
        pt_d      = rd_task_q;
        pk_d      = rd_key_q;
        lnk_we    = 1'b1;
        lnk_addr  = slot_q;
        lnk_wdata = free_q;
        free_d    = PW'(slot_q);
        head_d    = rd_link;
        if (rd_link >= NullSlot) begin
          head_d      = NullSlot;
          tail_d      = NullSlot;
          head_task_d = '0;
          state_d     = StDone;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_link[IW-1:0];
          state_d = StHdRd;
        end
      end

      StHdRd: begin
        head_task_d = rd_task_q;
        state_d     = StDone;
      end

      StDone: begin
        if (!m_tvalid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= NullSlot;
      tail_q      <= NullSlot;
      free_q      <= '0;
      head_task_q <= '0;
      m_tvalid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      free_q      <= free_d;
      head_task_q <= head_task_d;
      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= s_axis_tuser;
      task_q <= s_axis_tdata[TaskW-1:0];
      key_q  <= s_axis_tdata[TaskW+KeyW-1:TaskW];
    end
    slot_q <= slot_d;
    cur_q  <= cur_d;
    nxt_q  <= nxt_d;
    pv_q   <= pv_d;
    pt_q   <= pt_d;
    pk_q   <= pk_d;
    drop_q <= drop_d;
    if (out_load) begin
      m_tdata_q <= {(OutDataW - 51)'(0), drop_q,
                    (head_null ? '0 : head_task_q), head_null, pk_q, pt_q, pv_q};
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_head_tail_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIdle |-> ((head_q >= NullSlot) == (tail_q >= NullSlot)))
    else $error("head and tail disagree on an empty queue");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && free_q >= NullSlot) |-> !head_null)
    else $error("free list and queue both empty");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != StIdle)
    else $error("accepted beat not started");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == StDone)
    else $error("output beat raised outside the done state");

  a_no_link_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (lnk_we && rd_en) |-> lnk_addr != rd_addr)
    else $error("link write and read hit the same slot");

endmodule
